[design/wpcb_pkg.sv]
// ---------------------------------------------------------------------------
// wpcb_pkg
// Types and constants shared by the weighted point color binner.
// ---------------------------------------------------------------------------
package wpcb_pkg;

    localparam logic [2:0] CMD_CLEAR     = 3'd0;
    localparam logic [2:0] CMD_SET_COLOR = 3'd1;
    localparam logic [2:0] CMD_POINT     = 3'd2;
    localparam logic [2:0] CMD_READ      = 3'd3;
    localparam logic [2:0] CMD_MEDIAN    = 3'd4;

    localparam logic [2:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] CFG_INV_SCALE = 3'd2;
    localparam logic [2:0] CFG_TILE_LEFT = 3'd3;
    localparam logic [2:0] CFG_TILE_TOP  = 3'd4;
    localparam logic [2:0] CFG_TILE_W    = 3'd5;
    localparam logic [2:0] CFG_TILE_H    = 3'd6;

    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = 40;
    localparam int WGT_W   = 32;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [7:0]         feature_id;
        logic [15:0]        count;
        logic [7:0]         color_red;
        logic [7:0]         color_green;
        logic [7:0]         color_blue;
        logic               color_valid;
        logic [11:0]        pixel_index;
    } t_item;

    typedef struct packed {
        logic               status;
        logic [SUM_W-1:0]   red_sum;
        logic [SUM_W-1:0]   green_sum;
        logic [SUM_W-1:0]   blue_sum;
        logic [WGT_W-1:0]   weight_sum;
        logic [32:0]        median_twice;
        logic [12:0]        nonzero_pixels;
    } t_result;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
        logic [WGT_W-1:0] weight;
    } t_pix;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_PT_D,
        ST_PT_M0,
        ST_PT_M1,
        ST_PT_M2,
        ST_PT_PY,
        ST_PT_CHK,
        ST_PT_ADDR,
        ST_PT_R,
        ST_PT_G,
        ST_PT_B,
        ST_PT_WR,
        ST_RD_A,
        ST_RD_W,
        ST_MD_CNT,
        ST_MD_SETUP,
        ST_MD_SEL,
        ST_MD_DEC
    } t_state;

endpackage

[design/wpcb_mul.sv]
// ---------------------------------------------------------------------------
// wpcb_mul
// Shared 17 x 32 unsigned multiplier with a registered product.
// ---------------------------------------------------------------------------
module wpcb_mul (
    input  logic                         i_clk,
    input  logic [wpcb_pkg::MUL_A_W-1:0] i_a,
    input  logic [wpcb_pkg::MUL_B_W-1:0] i_b,
    output logic [wpcb_pkg::MUL_P_W-1:0] o_p
);
    import wpcb_pkg::*;

    logic [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

[design/wpcb_pix_mem.sv]
// ---------------------------------------------------------------------------
// wpcb_pix_mem
// Per-pixel color and weight sums, one write and one registered read port.
// ---------------------------------------------------------------------------
module wpcb_pix_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  wpcb_pkg::t_pix i_wdata,
    input  logic [AW-1:0]  i_raddr,
    output wpcb_pkg::t_pix o_rdata
);
    import wpcb_pkg::*;

    t_pix mem [DEPTH];
    t_pix r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_q <= mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

[design/weighted_point_color_binner_top.sv]
// ---------------------------------------------------------------------------
// weighted_point_color_binner_top
// Bins weighted points of one tile into per-pixel color and weight sums.
// ---------------------------------------------------------------------------
// After reset the block sweeps all MAX_TILE_SIDE^2 entries of the pixel
// store (4096 at the default) to zero with busy high. Each accepted item
// returns exactly one result, strobed on o_valid for one cycle, which the
// receiver must take. Set colour and unknown codes answer without leaving
// idle. For a point the coordinate products run as two 17 x 32 partial
// products per axis on one shared multiplier, which also forms the pixel
// address and the three color products. Clear writes every store entry
// once. Median is a bitwise radix select over the store's single read port:
// one counting pass plus 32 passes per middle value (64 on an even count),
// each pass a scan of width*height entries and each select pass followed by
// a decision state.
// ---------------------------------------------------------------------------
module weighted_point_color_binner_top #(
    parameter int MAX_TILE_SIDE = 64,
    parameter int NUM_FEATURES  = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  wpcb_pkg::t_item   i_item,
    output logic              o_valid,
    output wpcb_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);
    import wpcb_pkg::*;

    localparam int DEPTH  = MAX_TILE_SIDE * MAX_TILE_SIDE;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AREA_W = $clog2(DEPTH + 1);
    localparam int SW     = $clog2(MAX_TILE_SIDE + 1);
    localparam int PD     = (NUM_FEATURES < 256) ? NUM_FEATURES : 256;
    localparam int PW     = (PD > 1) ? $clog2(PD) : 1;

    // configuration
    logic signed [31:0] r_origin_x, r_origin_y;
    logic [31:0]        r_inv_scale;
    logic [15:0]        r_tile_left, r_tile_top;
    logic [6:0]         r_tile_w, r_tile_h;

    t_state r_state, n_state;
    t_item  r_in;

    logic [SW-1:0]     w_eff, h_eff;
    logic [AREA_W-1:0] r_area;

    // point datapath
    logic              r_axis, r_neg;
    logic [32:0]       r_mag;
    logic [MUL_P_W-1:0] r_lo;
    logic [41:0]       r_p;
    logic [43:0]       r_px, r_py;
    logic [AW-1:0]     r_addr;
    logic [23:0]       r_cr, r_cg;

    // scans and median select
    logic [AREA_W-1:0] r_scan, r_n, r_c0, r_k;
    logic              r_dv, r_first, r_even;
    logic [4:0]        r_bit;
    logic [31:0]       r_prefix, r_v1;

    // palette
    logic [23:0]   pal_mem [PD];
    logic [PD-1:0] r_pal_vld;
    logic [23:0]   r_pal_q;

    logic               mul_a_sel;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_pix          mem_wdata, mem_q;

    logic    acc, n_ov, r_ov;
    t_result n_out, r_out;

    assign acc         = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ov;
    assign o_result    = r_out;
    assign mul_a_sel   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_inv_scale <= 32'd65536;
            r_tile_left <= '0;
            r_tile_top  <= '0;
            r_tile_w    <= 7'd64;
            r_tile_h    <= 7'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:  r_origin_x  <= i_cfg_data;
                CFG_ORIGIN_Y:  r_origin_y  <= i_cfg_data;
                CFG_INV_SCALE: r_inv_scale <= i_cfg_data;
                CFG_TILE_LEFT: r_tile_left <= i_cfg_data[15:0];
                CFG_TILE_TOP:  r_tile_top  <= i_cfg_data[15:0];
                CFG_TILE_W:    r_tile_w    <= i_cfg_data[6:0];
                CFG_TILE_H:    r_tile_h    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign w_eff = (int'(r_tile_w) > MAX_TILE_SIDE) ? SW'(MAX_TILE_SIDE) : SW'(r_tile_w);
    assign h_eff = (int'(r_tile_h) > MAX_TILE_SIDE) ? SW'(MAX_TILE_SIDE) : SW'(r_tile_h);

    always_ff @(posedge i_clk) begin
        r_area <= AREA_W'(32'(w_eff) * 32'(h_eff));
    end

    // palette: valid bits in flops, colors in a small memory
    logic [PW-1:0] pal_widx, pal_ridx;
    logic          fid_ok_w, fid_ok_r;

    assign pal_widx = PW'(i_item.feature_id);
    assign pal_ridx = PW'(r_in.feature_id);
    assign fid_ok_w = (32'(i_item.feature_id) < NUM_FEATURES);
    assign fid_ok_r = (32'(r_in.feature_id) < NUM_FEATURES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_vld <= '0;
        end else if (acc && i_item.cmd == CMD_SET_COLOR && fid_ok_w) begin
            r_pal_vld[pal_widx] <= i_item.color_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_item.cmd == CMD_SET_COLOR && fid_ok_w && i_item.color_valid) begin
            pal_mem[pal_widx] <= {i_item.color_red, i_item.color_green, i_item.color_blue};
        end
        r_pal_q <= pal_mem[pal_ridx];
    end

    wpcb_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    wpcb_pix_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    // coordinate magnitude and signed pixel
    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [65:0]        prod_sum;
    logic [42:0]        p_signed;
    logic [15:0]        tile_sel;
    logic [43:0]        pix_val;

    always_comb begin
        if (r_axis) begin
            diff = 33'(r_in.coord_y) - 33'(r_origin_y);
        end else begin
            diff = 33'(r_in.coord_x) - 33'(r_origin_x);
        end
        mag      = diff[32] ? (33'd0 - diff) : diff;
        prod_sum = {17'd0, r_lo} + 66'({mul_p, 16'd0});
        p_signed = r_neg ? (43'd0 - {1'b0, r_p}) : {1'b0, r_p};
        tile_sel = (r_state == ST_PT_PY) ? r_tile_top : r_tile_left;
        pix_val  = {p_signed[42], p_signed} - {{28{tile_sel[15]}}, tile_sel};
    end

    logic drop;
    assign drop = (r_in.count == '0) || !fid_ok_r || !r_pal_vld[pal_ridx]
               || r_px[43] || r_py[43]
               || (r_px[42:0] >= 43'(w_eff)) || (r_py[42:0] >= 43'(h_eff));

    // saturating read-modify-write sums
    logic [40:0] sum_r, sum_g, sum_b;
    logic [32:0] sum_w;

    always_comb begin
        sum_r = {1'b0, mem_q.red}   + 41'(r_cr);
        sum_g = {1'b0, mem_q.green} + 41'(r_cg);
        sum_b = {1'b0, mem_q.blue}  + 41'(mul_p[23:0]);
        sum_w = {1'b0, mem_q.weight} + 33'(r_in.count);
    end

    // median radix select
    logic [32:0]       himask;
    logic              sel_match, k_le;
    logic [31:0]       new_prefix;
    logic              sel_done;

    always_comb begin
        himask     = {33{1'b1}} << ({1'b0, r_bit} + 6'd1);
        sel_match  = (mem_q.weight != '0) && (((mem_q.weight ^ r_prefix) & himask[31:0]) == '0)
                  && !mem_q.weight[r_bit];
        k_le       = (r_k <= r_c0);
        new_prefix = k_le ? r_prefix : (r_prefix | (32'd1 << r_bit));
        sel_done   = (r_bit == '0) && !(r_first && r_even);
    end

    logic pass_end;
    assign pass_end = (r_scan >= r_area) && !r_dv;

    // shared unit operands and store port
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        mem_raddr = r_addr;
        unique case (r_state)
            ST_PT_M0: begin
                mul_a = {1'b0, r_mag[15:0]};
                mul_b = r_inv_scale;
            end
            ST_PT_M1: begin
                mul_a = r_mag[32:16];
                mul_b = r_inv_scale;
            end
            ST_PT_CHK: begin
                mul_a = mul_a_sel ? '0 : r_py[16:0];
                mul_b = 32'(w_eff);
            end
            ST_PT_ADDR: begin
                mul_a = 17'(r_in.count);
                mul_b = 32'(r_pal_q[23:16]);
            end
            ST_PT_R: begin
                mul_a = 17'(r_in.count);
                mul_b = 32'(r_pal_q[15:8]);
            end
            // blue product is held so it is still on the output at the write
            ST_PT_G, ST_PT_B: begin
                mul_a = 17'(r_in.count);
                mul_b = 32'(r_pal_q[7:0]);
            end
            ST_PT_WR: begin
                mem_we           = 1'b1;
                mem_wdata.red    = sum_r[40] ? '1 : sum_r[39:0];
                mem_wdata.green  = sum_g[40] ? '1 : sum_g[39:0];
                mem_wdata.blue   = sum_b[40] ? '1 : sum_b[39:0];
                mem_wdata.weight = sum_w[32] ? '1 : sum_w[31:0];
            end
            ST_INIT, ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_scan[AW-1:0];
            end
            ST_RD_A, ST_RD_W: begin
                mem_raddr = AW'(r_in.pixel_index);
            end
            ST_MD_CNT, ST_MD_SEL: begin
                mem_raddr = r_scan[AW-1:0];
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT, ST_CLEAR: begin
                if (r_scan == AREA_W'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc) begin
                    priority case (i_item.cmd)
                        CMD_CLEAR:  n_state = ST_CLEAR;
                        CMD_POINT:  n_state = ST_PT_D;
                        CMD_READ:   n_state = ST_RD_A;
                        CMD_MEDIAN: n_state = ST_MD_CNT;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PT_D:    n_state = ST_PT_M0;
            ST_PT_M0:   n_state = ST_PT_M1;
            ST_PT_M1:   n_state = ST_PT_M2;
            ST_PT_M2:   n_state = r_axis ? ST_PT_PY : ST_PT_D;
            ST_PT_PY:   n_state = ST_PT_CHK;
            ST_PT_CHK:  n_state = drop ? ST_IDLE : ST_PT_ADDR;
            ST_PT_ADDR: n_state = ST_PT_R;
            ST_PT_R:    n_state = ST_PT_G;
            ST_PT_G:    n_state = ST_PT_B;
            ST_PT_B:    n_state = ST_PT_WR;
            ST_PT_WR:   n_state = ST_IDLE;
            ST_RD_A:    n_state = ST_RD_W;
            ST_RD_W:    n_state = ST_IDLE;
            ST_MD_CNT: begin
                if (pass_end) n_state = ST_MD_SETUP;
            end
            ST_MD_SETUP: n_state = (r_n == '0) ? ST_IDLE : ST_MD_SEL;
            ST_MD_SEL: begin
                if (pass_end) n_state = ST_MD_DEC;
            end
            ST_MD_DEC:  n_state = sel_done ? ST_IDLE : ST_MD_SEL;
            default:    n_state = ST_IDLE;
        endcase
    end

    // result
    always_comb begin
        n_ov  = 1'b0;
        n_out = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && i_item.cmd != CMD_CLEAR && i_item.cmd != CMD_POINT
                    && i_item.cmd != CMD_READ && i_item.cmd != CMD_MEDIAN) begin
                    n_ov = 1'b1;
                end
            end
            ST_CLEAR: begin
                n_ov = (r_scan == AREA_W'(DEPTH - 1));
            end
            ST_PT_CHK: begin
                n_ov         = drop;
                n_out.status = 1'b1;
            end
            ST_PT_WR: begin
                n_ov = 1'b1;
            end
            ST_RD_W: begin
                n_ov = 1'b1;
                if (32'(r_in.pixel_index) < 32'(r_area)) begin
                    n_out.red_sum    = mem_q.red;
                    n_out.green_sum  = mem_q.green;
                    n_out.blue_sum   = mem_q.blue;
                    n_out.weight_sum = mem_q.weight;
                end
            end
            ST_MD_SETUP: begin
                n_ov = (r_n == '0);
            end
            ST_MD_DEC: begin
                n_ov = sel_done;
                n_out.nonzero_pixels = 13'(r_n);
                if (r_even) begin
                    n_out.median_twice = {1'b0, r_v1} + {1'b0, new_prefix};
                end else begin
                    n_out.median_twice = {new_prefix, 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_ov    <= 1'b0;
            r_scan  <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            unique case (r_state)
                ST_INIT, ST_CLEAR: r_scan <= r_scan + 1'b1;
                ST_IDLE: begin
                    r_scan <= '0;
                    r_dv   <= 1'b0;
                end
                ST_MD_CNT, ST_MD_SEL: begin
                    if (r_scan < r_area) begin
                        r_scan <= r_scan + 1'b1;
                        r_dv   <= 1'b1;
                    end else begin
                        r_dv <= 1'b0;
                    end
                end
                ST_MD_SETUP, ST_MD_DEC: begin
                    r_scan <= '0;
                    r_dv   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (acc) begin
            r_in   <= i_item;
            r_axis <= 1'b0;
            r_n    <= '0;
        end
        unique case (r_state)
            ST_PT_D: begin
                r_mag <= mag;
                r_neg <= diff[32];
                if (r_axis) r_px <= pix_val;
            end
            ST_PT_M1: r_lo <= mul_p;
            ST_PT_M2: begin
                r_p    <= prod_sum[65:24];
                r_axis <= 1'b1;
            end
            ST_PT_PY:   r_py <= pix_val;
            ST_PT_ADDR: r_addr <= mul_p[AW-1:0] + r_px[AW-1:0];
            ST_PT_R:    r_cr <= mul_p[23:0];
            ST_PT_G:    r_cg <= mul_p[23:0];
            ST_MD_CNT: begin
                if (r_dv && mem_q.weight != '0) r_n <= r_n + 1'b1;
            end
            ST_MD_SETUP: begin
                r_even   <= !r_n[0];
                r_first  <= 1'b1;
                r_k      <= r_n[0] ? ((r_n + 1'b1) >> 1) : (r_n >> 1);
                r_bit    <= 5'd31;
                r_prefix <= '0;
                r_c0     <= '0;
            end
            ST_MD_SEL: begin
                if (r_dv && sel_match) r_c0 <= r_c0 + 1'b1;
            end
            ST_MD_DEC: begin
                r_c0 <= '0;
                if (r_bit == '0) begin
                    // first middle value found, go for the upper one
                    r_v1     <= new_prefix;
                    r_first  <= 1'b0;
                    r_k      <= (r_n >> 1) + 1'b1;
                    r_bit    <= 5'd31;
                    r_prefix <= '0;
                end else begin
                    r_bit    <= r_bit - 1'b1;
                    r_prefix <= new_prefix;
                    r_k      <= k_le ? r_k : (r_k - r_c0);
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    ap_point_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_item.cmd == CMD_POINT) |=> busy)
        else $error("point item did not start the sequencer");

    ap_drop_no_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status) |-> (o_result.weight_sum == '0
            && o_result.median_twice == '0))
        else $error("dropped point carries sums");

    ap_empty_median: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MD_SETUP && r_n == '0) |=> (o_valid && r_state == ST_IDLE))
        else $error("empty median did not answer");
`endif

endmodule
